>>> design/atfb_pkg.sv
// shared types and constants for the api transmit frame builder
// no dependencies
package atfb_pkg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out_beat;

    typedef enum logic [1:0] {
        S_HDR,
        S_DATA,
        S_CSUM
    } t_state;

    typedef enum logic [2:0] {
        CFG_DEST_LONG  = 3'd0,
        CFG_DEST_SHORT = 3'd1,
        CFG_FRAME_ID   = 3'd2,
        CFG_RADIUS     = 3'd3,
        CFG_OPTIONS    = 3'd4
    } t_cfg_idx;

    localparam int unsigned MAX_PAYLOAD_DEF = 255;
    localparam int unsigned CFG_DATA_W      = 64;
    localparam int unsigned HDR_IDX_W       = 5;

    localparam logic [7:0]  START_DELIM   = 8'h7E;
    localparam logic [7:0]  FRAME_TYPE    = 8'h10;
    localparam logic [8:0]  LEN_OVERHEAD  = 9'd14;

    localparam logic [HDR_IDX_W-1:0] HDR_START    = 5'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI   = 5'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO   = 5'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_TYPE     = 5'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_ID       = 5'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_LONG0    = 5'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_LONG7    = 5'd12;
    localparam logic [HDR_IDX_W-1:0] HDR_SHORT_HI = 5'd13;
    localparam logic [HDR_IDX_W-1:0] HDR_SHORT_LO = 5'd14;
    localparam logic [HDR_IDX_W-1:0] HDR_RADIUS   = 5'd15;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST     = 5'd16;

    localparam logic [63:0] DEST_LONG_RST  = 64'h0000_0000_0000_FFFF;
    localparam logic [15:0] DEST_SHORT_RST = 16'h0000;
    localparam logic [7:0]  FRAME_ID_RST   = 8'h00;
    localparam logic [7:0]  RADIUS_RST     = 8'h00;
    localparam logic [7:0]  OPTIONS_RST    = 8'h40;

endpackage

>>> design/api_transmit_frame_builder_unit.sv
// api transmit-request frame builder: header, payload pass-through, checksum
// depends on atfb_pkg
//
// channel | direction | handshake                | beat
// in      | input     | i_in_valid / o_in_ready  | atfb_pkg::t_in_beat
// out     | output    | o_out_valid / i_out_ready| atfb_pkg::t_out_beat
// cfg     | input     | i_cfg_we                 | i_cfg_idx, i_cfg_wdata
//
// one frame byte leaves per cycle through a single output register when not stalled
// first beat of a message: 17 header bytes, plus 1 payload byte, plus the checksum
// byte on the last beat; a zero-length message sends only header and checksum
// later beats send one byte, the closing beat two; the byte sequencer sets the rate
// a held input register takes the next beat in the cycle the current one finishes
// synchronous active-low reset returns to the header step with config at defaults
module api_transmit_frame_builder_unit #(
    parameter int unsigned MAX_PAYLOAD = atfb_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  atfb_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output atfb_pkg::t_out_beat                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_idx,
    input  logic [atfb_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import atfb_pkg::*;

    localparam logic [7:0] MAX_LEN = MAX_PAYLOAD[7:0];

    logic [63:0] r_dest_long;
    logic [15:0] r_dest_short;
    logic [7:0]  r_frame_id;
    logic [7:0]  r_radius;
    logic [7:0]  r_options;

    logic                 r_hv;
    t_in_beat             r_item;
    t_state               r_state, n_state;
    logic [HDR_IDX_W-1:0] r_hidx, n_hidx;
    logic [7:0]           r_remaining, n_remaining;
    logic [7:0]           r_sum, n_sum;
    logic                 r_ov;
    t_out_beat            r_out;

    logic       fire;
    logic       done;
    logic [7:0] len_sat;
    logic [8:0] total;
    logic [7:0] hdr_byte;
    logic [7:0] cur_byte;
    logic [2:0] long_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_long  <= DEST_LONG_RST;
            r_dest_short <= DEST_SHORT_RST;
            r_frame_id   <= FRAME_ID_RST;
            r_radius     <= RADIUS_RST;
            r_options    <= OPTIONS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEST_LONG:  r_dest_long  <= i_cfg_wdata;
                CFG_DEST_SHORT: r_dest_short <= i_cfg_wdata[15:0];
                CFG_FRAME_ID:   r_frame_id   <= i_cfg_wdata[7:0];
                CFG_RADIUS:     r_radius     <= i_cfg_wdata[7:0];
                CFG_OPTIONS:    r_options    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign len_sat  = (r_item.payload_length > MAX_LEN) ? MAX_LEN : r_item.payload_length;
    assign total    = {1'b0, len_sat} + LEN_OVERHEAD;
    assign long_sel = 3'(HDR_LONG7 - r_hidx);

    always_comb begin
        hdr_byte = START_DELIM;
        if (r_hidx >= HDR_LONG0 && r_hidx <= HDR_LONG7) begin
            hdr_byte = r_dest_long[{long_sel, 3'b000} +: 8];
        end else begin
            case (r_hidx)
                HDR_START:    hdr_byte = START_DELIM;
                HDR_LEN_HI:   hdr_byte = {7'd0, total[8]};
                HDR_LEN_LO:   hdr_byte = total[7:0];
                HDR_TYPE:     hdr_byte = FRAME_TYPE;
                HDR_ID:       hdr_byte = r_frame_id;
                HDR_SHORT_HI: hdr_byte = r_dest_short[15:8];
                HDR_SHORT_LO: hdr_byte = r_dest_short[7:0];
                HDR_RADIUS:   hdr_byte = r_radius;
                HDR_LAST:     hdr_byte = r_options;
                default:      hdr_byte = START_DELIM;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_HDR:   cur_byte = hdr_byte;
            S_DATA:  cur_byte = r_item.payload_byte;
            S_CSUM:  cur_byte = ~r_sum;
            default: cur_byte = hdr_byte;
        endcase
    end

    assign fire = r_hv && (!r_ov || i_out_ready);
    assign done = fire && ((r_state == S_DATA && r_remaining != 8'd1) || r_state == S_CSUM);
    assign o_in_ready = !r_hv || done;

    // next step of the byte sequencer
    always_comb begin
        n_state     = r_state;
        n_hidx      = r_hidx;
        n_remaining = r_remaining;
        n_sum       = r_sum;
        if (fire) begin
            unique case (r_state)
                S_HDR: begin
                    if (r_hidx == HDR_TYPE) begin
                        n_sum = FRAME_TYPE;
                    end else if (r_hidx > HDR_TYPE) begin
                        n_sum = r_sum + cur_byte;
                    end
                    if (r_hidx == HDR_LAST) begin
                        n_hidx      = HDR_START;
                        n_remaining = len_sat;
                        n_state     = (len_sat == 8'd0) ? S_CSUM : S_DATA;
                    end else begin
                        n_hidx = r_hidx + 5'd1;
                    end
                end
                S_DATA: begin
                    n_sum       = r_sum + cur_byte;
                    n_remaining = r_remaining - 8'd1;
                    if (r_remaining == 8'd1) begin
                        n_state = S_CSUM;
                    end
                end
                S_CSUM: begin
                    n_sum   = 8'd0;
                    n_hidx  = HDR_START;
                    n_state = S_HDR;
                end
                default: n_state = S_HDR;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv        <= 1'b0;
            r_state     <= S_HDR;
            r_hidx      <= HDR_START;
            r_remaining <= 8'd0;
            r_sum       <= 8'd0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hidx      <= n_hidx;
            r_remaining <= n_remaining;
            r_sum       <= n_sum;
            if (o_in_ready) begin
                r_hv <= i_in_valid;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= i_in_data;
        end
        if (fire) begin
            r_out.frame_byte <= cur_byte;
            r_out.frame_end  <= (r_state == S_CSUM);
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_data_has_bytes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_remaining != 8'd0))
        else $error("data step with no bytes left");

    a_hidx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hidx <= HDR_LAST))
        else $error("header index out of range");

    a_csum_restarts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_state == S_CSUM) |=> (r_state == S_HDR && r_hidx == HDR_START))
        else $error("checksum not followed by header start");

endmodule

>>> dv/tb_api_transmit_frame_builder_unit.sv
// testbench for the api transmit frame builder: random messages and register settings,
// every frame byte checked against an in-bench frame predictor
// depends on atfb_pkg and api_transmit_frame_builder_unit
module tb_api_transmit_frame_builder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import atfb_pkg::*;

    localparam int unsigned ITEMS_TARGET = 450;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam logic [2:0]  CFG_IDX_MAX  = '1;

    typedef enum int {
        SET_ZERO,
        SET_ONES,
        SET_RANDOM
    } t_setting;

    class frame_scoreboard;
        logic [63:0] dest_long;
        logic [15:0] dest_short;
        logic [7:0]  frame_id;
        logic [7:0]  radius;
        logic [7:0]  options;
        bit          in_msg;
        logic [7:0]  remaining;
        logic [7:0]  csum;
        t_out_beat   frame_q[$];
        int          errors;

        function new();
            dest_long  = DEST_LONG_RST;
            dest_short = DEST_SHORT_RST;
            frame_id   = FRAME_ID_RST;
            radius     = RADIUS_RST;
            options    = OPTIONS_RST;
            in_msg     = 1'b0;
            remaining  = '0;
            csum       = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] v);
            case (idx)
                CFG_DEST_LONG:  dest_long  = v;
                CFG_DEST_SHORT: dest_short = v[15:0];
                CFG_FRAME_ID:   frame_id   = v[7:0];
                CFG_RADIUS:     radius     = v[7:0];
                CFG_OPTIONS:    options    = v[7:0];
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic last, bit summed);
            t_out_beat o;
            o.frame_byte = b;
            o.frame_end  = last;
            frame_q.push_back(o);
            if (summed) csum = csum + b;
        endfunction

        function void note_beat(t_in_beat b);
            logic [15:0] total;
            if (!in_msg) begin
                total = 16'(b.payload_length) + 16'(LEN_OVERHEAD);
                csum  = '0;
                push_byte(START_DELIM, 1'b0, 0);
                push_byte(total[15:8], 1'b0, 0);
                push_byte(total[7:0], 1'b0, 0);
                push_byte(FRAME_TYPE, 1'b0, 1);
                push_byte(frame_id, 1'b0, 1);
                for (int k = 7; k >= 0; k--) push_byte(dest_long[8*k +: 8], 1'b0, 1);
                push_byte(dest_short[15:8], 1'b0, 1);
                push_byte(dest_short[7:0], 1'b0, 1);
                push_byte(radius, 1'b0, 1);
                push_byte(options, 1'b0, 1);
                if (b.payload_length == 0) begin
                    push_byte(8'hFF - csum, 1'b1, 0);
                    csum = '0;
                    return;
                end
                in_msg    = 1'b1;
                remaining = b.payload_length;
            end
            push_byte(b.payload_byte, 1'b0, 1);
            remaining = remaining - 1;
            if (remaining == 0) begin
                push_byte(8'hFF - csum, 1'b1, 0);
                in_msg = 1'b0;
                csum   = '0;
            end
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat exp_b;
            if (frame_q.size() == 0) begin
                $error("unexpected frame beat: frame_byte %02h frame_end %0b",
                       got.frame_byte, got.frame_end);
                errors++;
                return;
            end
            exp_b = frame_q.pop_front();
            if (got.frame_byte !== exp_b.frame_byte) begin
                $error("frame_byte mismatch: expected %02h, actual %02h",
                       exp_b.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.frame_end !== exp_b.frame_end) begin
                $error("frame_end mismatch: expected %0b, actual %0b",
                       exp_b.frame_end, got.frame_end);
                errors++;
            end
        endfunction

        function int pending();
            return frame_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_ready;
    t_in_beat    in_data;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out_beat   o_out_data;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [63:0] cfg_wdata;

    frame_scoreboard sb;
    bit          quiet;
    int unsigned items_sent;
    int unsigned idle_cycles;
    int          stall_left;
    int          out_gap;

    api_transmit_frame_builder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 75) return $urandom_range(1, 8);
        if (r < 97) return $urandom_range(9, 40);
        return $urandom_range(100, MAX_PAYLOAD_DEF);
    endfunction

    // output side: random backpressure, check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) sb.check_beat(o_out_data);
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_gap = pick_gap();
            if (out_gap > 0) begin
                stall_left = out_gap - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_beat(t_in_beat b);
        int g;
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_beat(b);
        items_sent++;
    endtask

    // first beat carries the length; later beats carry junk in the length field
    task automatic send_message(int len, int first_byte);
        t_in_beat b;
        int beats;
        beats = (len == 0) ? 1 : len;
        for (int k = 0; k < beats; k++) begin
            b.payload_byte   = (k == 0 && first_byte >= 0) ? 8'(first_byte) : 8'($urandom);
            b.payload_length = (k == 0) ? 8'(len) : 8'($urandom);
            send_beat(b);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(t_setting s);
        logic [63:0] v [5];
        for (int i = 0; i < 5; i++) begin
            case (s)
                SET_ZERO: v[i] = '0;
                SET_ONES: v[i] = '1;
                default:  v[i] = {$urandom, $urandom};
            endcase
        end
        write_reg(CFG_DEST_LONG,  v[0]);
        write_reg(CFG_DEST_SHORT, v[1]);
        write_reg(CFG_FRAME_ID,   v[2]);
        write_reg(CFG_RADIUS,     v[3]);
        write_reg(CFG_OPTIONS,    v[4]);
        // unknown index must leave every register alone
        write_reg(3'($urandom_range(CFG_OPTIONS + 1, CFG_IDX_MAX)), {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    initial begin
        int  phase;
        int  n_msgs;
        int  len;
        bit  long_done;
        t_setting s;

        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_idx     = '0;
        cfg_wdata   = '0;
        i_rst_n     = 1'b0;
        quiet       = 1'b0;
        items_sent  = 0;
        idle_cycles = 0;
        stall_left  = 0;
        long_done   = 1'b0;
        sb          = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, zero-length, single-byte extremes
        send_message(0, 8'hFF);
        send_message(1, 8'h00);
        send_message(1, 8'hFF);
        send_message(3, START_DELIM);
        send_message(2, -1);
        wait_drain();
        apply_setting(SET_ZERO);
        send_message(0, 8'h00);
        send_message(2, 8'hFF);
        wait_drain();
        apply_setting(SET_ONES);
        send_message(1, 8'hFF);
        send_message(4, 8'h00);
        send_message(0, -1);
        wait_drain();

        phase = 0;
        while (items_sent < ITEMS_TARGET) begin
            phase++;
            case (phase % 7)
                0:       s = SET_ZERO;
                1:       s = SET_ONES;
                default: s = SET_RANDOM;
            endcase
            quiet = ($urandom_range(0, 4) == 0);
            apply_setting(s);
            n_msgs = $urandom_range(3, 8);
            for (int m = 0; m < n_msgs; m++) begin
                len = pick_length();
                if (!long_done && phase >= 3) begin
                    len       = MAX_PAYLOAD_DEF;
                    long_done = 1'b1;
                end
                send_message(len, -1);
            end
            wait_drain();
        end

        quiet = 1'b0;
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/atfb_pkg.sv
design/api_transmit_frame_builder_unit.sv
dv/tb_api_transmit_frame_builder_unit.sv
